FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is asserted.
`define LRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property that must hold exactly on the cycle it names, reset or not.
`define LRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/lrf_pkg.sv
`default_nettype none

package lrf_pkg;

  // Geometry of the line store
  localparam int NUM_LINES      = 16;
  localparam int MAX_LINE_BYTES = 64;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int SLOT_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int POS_W  = $clog2(MAX_LINE_BYTES);
  localparam int HELD_W = $clog2(NUM_LINES + 1);
  localparam int ADDR_W = SLOT_W + POS_W;

  // Most bytes one slot keeps
  localparam int LINE_LIMIT = MAX_LINE_BYTES - 1;

  // Command codes
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [BYTE_W-1:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last_of_line;
    logic [1:0]        status;
    logic [LEN_W-1:0]  line_length;
  } res_t;

  // Controller to memory requests
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } byte_req_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [LEN_W-1:0]  wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } len_req_t;

endpackage

`default_nettype wire

FILE: rtl/lrf_ram.sv
`default_nettype none

module lrf_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register read data, hold it between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lrf_ctrl.sv
`default_nettype none

module lrf_ctrl
  import lrf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire req_t              req_i,
  output logic                   res_strobe_o,
  output res_t                   res_o,
  output byte_req_t              byte_req_o,
  input  wire logic [BYTE_W-1:0] byte_rdata_i,
  output len_req_t               len_req_o,
  input  wire logic [LEN_W-1:0]  len_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LEN    = 3'b010,
    S_STREAM = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] wslot_q, wslot_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic [POS_W-1:0]  wpos_q, wpos_d;
  logic [POS_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              strobe_q, strobe_d;
  res_t              res_q, res_d;

  logic              full;
  logic              accept;
  logic [LEN_W-1:0]  len_fetched;
  logic              last_byte;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    if (s == SLOT_W'(NUM_LINES - 1)) begin
      n = '0;
    end else begin
      n = s + SLOT_W'(1);
    end
    return n;
  endfunction

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = (held_q == HELD_W'(NUM_LINES));

  // Clamp the stored length to what a slot can hold
  assign len_fetched = (len_rdata_i > LEN_W'(LINE_LIMIT)) ? LEN_W'(LINE_LIMIT) : len_rdata_i;
  assign last_byte   = (idx_q == POS_W'(len_q - LEN_W'(1)));

  // Decode the command, sequence a read through length and byte fetches
  always_comb begin
    state_d       = state_q;
    wslot_d       = wslot_q;
    rslot_d       = rslot_q;
    rd_slot_d     = rd_slot_q;
    held_d        = held_q;
    wpos_d        = wpos_q;
    idx_d         = idx_q;
    len_d         = len_q;
    strobe_d      = 1'b0;
    res_d         = res_q;
    byte_req_o.we = 1'b0;
    byte_req_o.re = 1'b0;
    len_req_o.we  = 1'b0;
    len_req_o.re  = 1'b0;

    // Memory addresses follow the slot registers directly
    byte_req_o.waddr = {wslot_q, wpos_q};
    byte_req_o.wdata = req_i.data_byte;
    byte_req_o.raddr = (state_q == S_LEN) ? {rd_slot_q, {POS_W{1'b0}}}
                                          : {rd_slot_q, idx_q + POS_W'(1)};
    len_req_o.waddr  = wslot_q;
    len_req_o.wdata  = LEN_W'(wpos_q);
    len_req_o.raddr  = rslot_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.cmd)
            CMD_WRITE: begin
              // Store the byte unless the line is at its limit; drop it while full
              if (wpos_q < POS_W'(LINE_LIMIT)) begin
                byte_req_o.we = !full;
                wpos_d        = wpos_q + POS_W'(1);
              end
            end
            CMD_COMMIT: begin
              strobe_d             = 1'b1;
              res_d.out_byte       = '0;
              res_d.byte_valid     = 1'b0;
              res_d.last_of_line   = 1'b1;
              res_d.status         = full ? ST_FULL : ST_OK;
              res_d.line_length    = LEN_W'(wpos_q);
              wpos_d               = '0;
              if (!full) begin
                len_req_o.we = 1'b1;
                wslot_d      = next_slot(wslot_q);
                held_d       = held_q + HELD_W'(1);
              end
            end
            CMD_READ: begin
              if (held_q == '0) begin
                strobe_d           = 1'b1;
                res_d.out_byte     = '0;
                res_d.byte_valid   = 1'b0;
                res_d.last_of_line = 1'b1;
                res_d.status       = ST_EMPTY;
                res_d.line_length  = '0;
              end else begin
                len_req_o.re = 1'b1;
                rd_slot_d    = rslot_q;
                rslot_d      = next_slot(rslot_q);
                held_d       = held_q - HELD_W'(1);
                state_d      = S_LEN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LEN: begin
        len_d = len_fetched;
        if (len_fetched == '0) begin
          // Empty line: one marker transfer
          strobe_d           = 1'b1;
          res_d.out_byte     = '0;
          res_d.byte_valid   = 1'b0;
          res_d.last_of_line = 1'b1;
          res_d.status       = ST_OK;
          res_d.line_length  = '0;
          state_d            = S_IDLE;
        end else begin
          byte_req_o.re = 1'b1;
          idx_d         = '0;
          state_d       = S_STREAM;
        end
      end
      S_STREAM: begin
        // Emit the fetched byte, fetch the next one
        strobe_d           = 1'b1;
        res_d.out_byte     = byte_rdata_i;
        res_d.byte_valid   = 1'b1;
        res_d.last_of_line = last_byte;
        res_d.status       = ST_OK;
        res_d.line_length  = last_byte ? len_q : '0;
        if (last_byte) begin
          state_d = S_IDLE;
        end else begin
          byte_req_o.re = 1'b1;
          idx_d         = idx_q + POS_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wslot_q  <= '0;
      rslot_q  <= '0;
      held_q   <= '0;
      wpos_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wslot_q  <= wslot_d;
      rslot_q  <= rslot_d;
      held_q   <= held_d;
      wpos_q   <= wpos_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_slot_q <= rd_slot_d;
    idx_q     <= idx_d;
    len_q     <= len_d;
    res_q     <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

FILE: rtl/line_record_fifo.sv
// Ring FIFO of variable-length lines, NUM_LINES slots of MAX_LINE_BYTES-1 bytes
// each. A write item gives no result; bytes past the slot limit, and bytes
// that arrive while every slot is full, are dropped. A commit item gives one
// result on the following cycle, with status full when the line was
// discarded. A read item of an empty FIFO gives one empty result. A read of a
// line of n bytes keeps busy high while the S_LEN state fetches the stored
// length, then while the byte memory's single read port delivers one byte per
// cycle; a zero-length line gives its marker right after the length fetch.
// start is taken again on the cycle the last result appears. Each result
// stands on the result ports for exactly one cycle under res_strobe_o; the
// receiver must take it then, as there is no way to hold results back.
`default_nettype none

`include "assert_macros.svh"

module line_record_fifo
  import lrf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      res_strobe_o,
  output res_t      res_o
);

  byte_req_t         byte_req;
  len_req_t          len_req;
  logic [BYTE_W-1:0] byte_rdata;
  logic [LEN_W-1:0]  len_rdata;

  // Sequence commands and reads
  lrf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .byte_req_o   (byte_req),
    .byte_rdata_i (byte_rdata),
    .len_req_o    (len_req),
    .len_rdata_i  (len_rdata)
  );

  // Line bytes, addressed by slot and position
  lrf_ram #(
    .WIDTH  (BYTE_W),
    .ADDR_W (ADDR_W)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_req.we),
    .waddr_i (byte_req.waddr),
    .wdata_i (byte_req.wdata),
    .re_i    (byte_req.re),
    .raddr_i (byte_req.raddr),
    .rdata_o (byte_rdata)
  );

  // Line lengths, one per slot
  lrf_ram #(
    .WIDTH  (LEN_W),
    .ADDR_W (SLOT_W)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_req.we),
    .waddr_i (len_req.waddr),
    .wdata_i (len_req.wdata),
    .re_i    (len_req.re),
    .raddr_i (len_req.raddr),
    .rdata_o (len_rdata)
  );

  // A write transfer never produces a result
  `LRF_ASSERT(a_write_silent, start && !busy && req_i.cmd == CMD_WRITE |=> !res_strobe_o, "write gave a result")
  // Busy only begins after a read transfer
  `LRF_ASSERT(a_busy_from_read, $rose(busy) |-> $past(start) && $past(req_i.cmd) == CMD_READ, "busy without read")
  // No byte is stored while a read is streaming
  `LRF_ASSERT(a_no_write_busy, byte_req.we |-> !busy, "byte stored during read")
  // Length store is never written and read in one cycle
  `LRF_ASSERT_ALWAYS(a_len_port, !(len_req.we && len_req.re), "length store conflict")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lrf_pkg::*;

  // Command code that the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  // Longest read keeps the block busy through a length fetch and a full slot
  localparam int DRAIN_CYCLES = 2 * MAX_LINE_BYTES + 16;

  // Line FIFO predictor and queue of results still due
  class line_fifo_model;
    logic [BYTE_W-1:0] byte_mem [NUM_LINES*MAX_LINE_BYTES];
    logic [LEN_W-1:0]  len_mem  [NUM_LINES];
    int slot_fill [NUM_LINES];
    int wr_slot;
    int rd_slot;
    int held;
    int wr_pos;
    int dark_end;
    int failures;
    res_t results_due[$];

    function new();
      wr_slot  = 0;
      rd_slot  = 0;
      held     = 0;
      wr_pos   = 0;
      dark_end = 0;
      failures = 0;
      foreach (slot_fill[s]) slot_fill[s] = 0;
    endfunction

    function int next_slot(int s);
      return (s + 1 >= NUM_LINES) ? 0 : s + 1;
    endfunction

    // A read while full frees the slot of the open line; refuse it if bytes
    // that arrived while full would land on positions never written
    function bit read_is_safe();
      return !(held >= NUM_LINES && dark_end > slot_fill[wr_slot]);
    endfunction

    function int outstanding();
      return results_due.size();
    endfunction

    // Advance the predicted state by one accepted transfer
    function void note_request(req_t r);
      res_t res;
      logic [LEN_W-1:0] n;
      bit full;
      full = (held >= NUM_LINES);
      res = '0;
      case (r.cmd)
        CMD_WRITE: begin
          if (wr_pos < LINE_LIMIT) begin
            if (!full) begin
              byte_mem[wr_slot*MAX_LINE_BYTES + wr_pos] = r.data_byte;
              if (slot_fill[wr_slot] < wr_pos + 1) slot_fill[wr_slot] = wr_pos + 1;
            end else if (dark_end < wr_pos + 1) begin
              dark_end = wr_pos + 1;
            end
            wr_pos++;
          end
        end
        CMD_COMMIT: begin
          res.last_of_line = 1'b1;
          res.line_length  = LEN_W'(wr_pos);
          res.status       = full ? ST_FULL : ST_OK;
          if (!full) begin
            len_mem[wr_slot] = LEN_W'(wr_pos);
            wr_slot = next_slot(wr_slot);
            held++;
          end
          wr_pos   = 0;
          dark_end = 0;
          results_due.push_back(res);
        end
        CMD_READ: begin
          if (held == 0) begin
            res.last_of_line = 1'b1;
            res.status       = ST_EMPTY;
            results_due.push_back(res);
          end else begin
            n = len_mem[rd_slot];
            if (n == 0) begin
              res.last_of_line = 1'b1;
              results_due.push_back(res);
            end else begin
              for (int i = 0; i < int'(n); i++) begin
                res              = '0;
                res.out_byte     = byte_mem[rd_slot*MAX_LINE_BYTES + i];
                res.byte_valid   = 1'b1;
                res.last_of_line = (i + 1 == int'(n));
                res.line_length  = res.last_of_line ? n : '0;
                results_due.push_back(res);
              end
            end
            rd_slot = next_slot(rd_slot);
            held--;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result with the oldest one due
    function void check_result(res_t got);
      res_t want;
      if (results_due.size() == 0) begin
        $error("result with none due: %h", got);
        failures++;
        return;
      end
      want = results_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h actual %0h", want.out_byte, got.out_byte);
        failures++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0h actual %0h", want.byte_valid, got.byte_valid);
        failures++;
      end
      if (got.last_of_line !== want.last_of_line) begin
        $error("last_of_line: expected %0h actual %0h", want.last_of_line, got.last_of_line);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0h actual %0h", want.status, got.status);
        failures++;
      end
      if (got.line_length !== want.line_length) begin
        $error("line_length: expected %0h actual %0h", want.line_length, got.line_length);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_strobe_o;
  res_t res_o;

  line_fifo_model fifo_model;
  int items_sent;
  int idle_pct;
  int cycle_count;

  line_record_fifo i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Check every strobed result
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) fifo_model.check_result(res_o);
  end

  // Hold one item until its transfer, then idle at random
  task automatic send_item(logic [1:0] cmd, logic [BYTE_W-1:0] data);
    req_t r;
    r.cmd       = cmd;
    r.data_byte = data;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    fifo_model.note_request(r);
    if (cmd != CMD_UNUSED) items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Read, unless that would expose never-written bytes; close the line then
  task automatic send_read();
    if (fifo_model.read_is_safe()) send_item(CMD_READ, BYTE_W'($urandom));
    else send_item(CMD_COMMIT, BYTE_W'($urandom));
  endtask

  // One line of random bytes with the odd read slipped in, then its commit
  task automatic send_line(int len);
    for (int i = 0; i < len; i++) begin
      send_item(CMD_WRITE, BYTE_W'($urandom));
      if ($urandom_range(99) < 5) send_read();
    end
    send_item(CMD_COMMIT, BYTE_W'($urandom));
  endtask

  task automatic run_phase(int idle, int read_pct, int max_len, int long_pct, int quota);
    int first;
    int pick;
    idle_pct = idle;
    first    = items_sent;
    while (items_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < read_pct) begin
        send_read();
      end else if (pick < read_pct + 6) begin
        send_item(CMD_UNUSED, BYTE_W'($urandom));
      end else if (pick < read_pct + 10) begin
        send_item(CMD_WRITE, BYTE_W'($urandom));
      end else if ($urandom_range(99) < long_pct) begin
        send_line($urandom_range(LINE_LIMIT - 4, LINE_LIMIT + 9));
      end else begin
        send_line($urandom_range(0, max_len));
      end
    end
  endtask

  initial begin
    fifo_model  = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    items_sent  = 0;
    idle_pct    = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extreme bytes, empty read, zero-length and one-byte lines,
    // the unused command
    send_item(CMD_WRITE, 8'h00);
    send_item(CMD_WRITE, 8'hFF);
    send_item(CMD_COMMIT, 8'h00);
    send_item(CMD_READ, 8'hFF);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_COMMIT, 8'hFF);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_UNUSED, 8'h5A);
    send_item(CMD_WRITE, 8'h80);
    send_item(CMD_COMMIT, 8'h7F);
    send_item(CMD_READ, 8'hA5);
    send_item(CMD_READ, 8'h5A);

    // Random: a truncated line first, then fill up, drain and mix
    idle_pct = 0;
    send_line($urandom_range(LINE_LIMIT, LINE_LIMIT + 8));
    send_read();
    run_phase(0, 35, 8, 0, 20);
    run_phase(52, 4, 2, 0, 40);
    run_phase(0, 60, 6, 0, 15);
    run_phase(15, 30, 8, 2, 20);

    // Drop start and let the last results come out
    start <= 1'b0;
    while (fifo_model.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fifo_model.failures == 0 && fifo_model.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lrf_pkg.sv
rtl/lrf_ram.sv
rtl/lrf_ctrl.sv
rtl/line_record_fifo.sv
tb/sv/testbench.sv
